// ===== rtl/core/blpg_pkg.sv =====
// Package for the Bresenham line pixel generator.
// Holds shared constants, the walker status type and the command width helper.
// No dependencies.
`default_nettype none

package blpg_pkg;

   localparam int COORD_BITS_DEFAULT = 6;
   localparam int COLOUR_BITS        = 32;
   localparam int QUEUE_DEPTH        = 2;

   typedef struct packed {
      logic busy;
      logic emit;
      logic emit_last;
      logic take;
   } walk_status_type;

   function automatic int error_bits(input int coord_bits);
      return coord_bits + 3;
   endfunction

   function automatic int cmd_bits(input int coord_bits);
      return 3 * coord_bits + 3 * error_bits(coord_bits) + 2 + COLOUR_BITS;
   endfunction

endpackage

`default_nettype wire

// ===== rtl/core/blpg_if.sv =====
// Channel interfaces for the Bresenham line pixel generator.
// The request channel carries line commands, the response channel pixels.
// Depends on blpg_pkg.
`default_nettype none

interface blpg_req_if #(
   parameter int COORD_BITS = blpg_pkg::COORD_BITS_DEFAULT
);
   logic                               valid;
   logic                               ready;
   logic [COORD_BITS-1:0]              start_x;
   logic [COORD_BITS-1:0]              start_y;
   logic [COORD_BITS-1:0]              end_x;
   logic [COORD_BITS-1:0]              end_y;
   logic [blpg_pkg::COLOUR_BITS-1:0]   colour;

   modport source (output valid, start_x, start_y, end_x, end_y, colour, input ready);
   modport sink   (input valid, start_x, start_y, end_x, end_y, colour, output ready);
endinterface

interface blpg_rsp_if #(
   parameter int COORD_BITS = blpg_pkg::COORD_BITS_DEFAULT
);
   logic                               valid;
   logic                               ready;
   logic [COORD_BITS-1:0]              pixel_x;
   logic [COORD_BITS-1:0]              pixel_y;
   logic [blpg_pkg::COLOUR_BITS-1:0]   pixel_colour;
   logic                               last;

   modport source (output valid, pixel_x, pixel_y, pixel_colour, last, input ready);
   modport sink   (input valid, pixel_x, pixel_y, pixel_colour, last, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/blpg_front.sv =====
// Front end of the line generator: accepts a command, picks the major axis,
// orders the endpoints and derives the error terms for the walker.
// Depends on blpg_pkg and blpg_req_if.
`default_nettype none

module blpg_front #(
   parameter int COORD_BITS = blpg_pkg::COORD_BITS_DEFAULT,
   parameter int CMD_BITS   = blpg_pkg::cmd_bits(blpg_pkg::COORD_BITS_DEFAULT)
) (
   input  wire logic                clock,
   input  wire logic                reset,
   blpg_req_if.sink                 req_if,
   output      logic                push,
   output      logic [CMD_BITS-1:0] push_data,
   input  wire logic                full
);
   import blpg_pkg::*;

   localparam int EB = error_bits(COORD_BITS);

   typedef struct packed {
      logic [COORD_BITS-1:0]  start_major;
      logic [COORD_BITS-1:0]  start_minor;
      logic [COORD_BITS-1:0]  stop_major;
      logic signed [EB-1:0]   error_init;
      logic signed [EB-1:0]   inc_step;
      logic signed [EB-1:0]   inc_hold;
      logic                   step_down;
      logic                   steep;
      logic [COLOUR_BITS-1:0] colour;
   } cmd_type;

   logic                   valid_ff, valid_in;
   logic [COORD_BITS-1:0]  a0_ff, b0_ff, a1_ff, b1_ff;
   logic [COORD_BITS-1:0]  a0_in, b0_in, a1_in, b1_in;
   logic                   steep_ff, steep_in;
   logic [COLOUR_BITS-1:0] colour_ff, colour_in;

   logic signed [COORD_BITS:0] dx, dy, dmin;
   logic [COORD_BITS-1:0]      adx, ady, admin, dmaj;
   logic                       shallow, swap, take;
   logic signed [EB-1:0]       twice_min, twice_maj;
   cmd_type                    cmd;

   assign req_if.ready = !valid_ff || !full;
   assign take         = req_if.valid && req_if.ready;

   always_comb begin
      dx      = $signed({1'b0, req_if.end_x}) - $signed({1'b0, req_if.start_x});
      dy      = $signed({1'b0, req_if.end_y}) - $signed({1'b0, req_if.start_y});
      adx     = dx[COORD_BITS] ? COORD_BITS'(-dx) : dx[COORD_BITS-1:0];
      ady     = dy[COORD_BITS] ? COORD_BITS'(-dy) : dy[COORD_BITS-1:0];
      shallow = ady < adx;
      swap    = shallow ? (req_if.start_x > req_if.end_x) : (req_if.start_y > req_if.end_y);
      if (shallow) begin
         a0_in = swap ? req_if.end_x : req_if.start_x;
         b0_in = swap ? req_if.end_y : req_if.start_y;
         a1_in = swap ? req_if.start_x : req_if.end_x;
         b1_in = swap ? req_if.start_y : req_if.end_y;
      end else begin
         a0_in = swap ? req_if.end_y : req_if.start_y;
         b0_in = swap ? req_if.end_x : req_if.start_x;
         a1_in = swap ? req_if.start_y : req_if.end_y;
         b1_in = swap ? req_if.start_x : req_if.end_x;
      end
      steep_in  = !shallow;
      colour_in = req_if.colour;
      if (take) begin
         valid_in = 1'b1;
      end else if (!full) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      if (take) begin
         a0_ff     <= a0_in;
         b0_ff     <= b0_in;
         a1_ff     <= a1_in;
         b1_ff     <= b1_in;
         steep_ff  <= steep_in;
         colour_ff <= colour_in;
      end
   end

   always_comb begin
      dmaj      = a1_ff - a0_ff;
      dmin      = $signed({1'b0, b1_ff}) - $signed({1'b0, b0_ff});
      admin     = dmin[COORD_BITS] ? COORD_BITS'(-dmin) : dmin[COORD_BITS-1:0];
      twice_min = $signed({2'b00, admin, 1'b0});
      twice_maj = $signed({2'b00, dmaj, 1'b0});
      cmd.start_major = a0_ff;
      cmd.start_minor = b0_ff;
      cmd.stop_major  = a1_ff;
      cmd.error_init  = twice_min - $signed({3'b000, dmaj});
      cmd.inc_step    = twice_min - twice_maj;
      cmd.inc_hold    = twice_min;
      cmd.step_down   = dmin[COORD_BITS];
      cmd.steep       = steep_ff;
      cmd.colour      = colour_ff;
   end

   assign push      = valid_ff && !full;
   assign push_data = cmd;

endmodule

`default_nettype wire

// ===== rtl/core/blpg_queue.sv =====
// Short command queue between the front end and the pixel walker.
// Depth comes from blpg_pkg; width is a parameter.
// Depends on blpg_pkg.
`default_nettype none

module blpg_queue #(
   parameter int DATA_BITS = blpg_pkg::cmd_bits(blpg_pkg::COORD_BITS_DEFAULT)
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 push,
   input  wire logic [DATA_BITS-1:0] push_data,
   output      logic                 full,
   input  wire logic                 pop,
   output      logic [DATA_BITS-1:0] pop_data,
   output      logic                 empty
);
   import blpg_pkg::*;

   localparam int PTR_BITS = $clog2(QUEUE_DEPTH);
   localparam int CNT_BITS = $clog2(QUEUE_DEPTH + 1);

   logic [DATA_BITS-1:0] mem [QUEUE_DEPTH];
   logic [PTR_BITS-1:0]  wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CNT_BITS-1:0]  count_ff, count_in;

   assign full     = count_ff == CNT_BITS'(QUEUE_DEPTH);
   assign empty    = count_ff == '0;
   assign pop_data = mem[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push) begin
         mem[wr_ptr_ff] <= push_data;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/core/blpg_walker.sv =====
// Back end of the line generator: walks one line command along its major
// axis and emits one pixel per cycle while rsp_if accepts, through a registered output.
// Depends on blpg_pkg and blpg_rsp_if.
`default_nettype none

module blpg_walker #(
   parameter int COORD_BITS = blpg_pkg::COORD_BITS_DEFAULT,
   parameter int CMD_BITS   = blpg_pkg::cmd_bits(blpg_pkg::COORD_BITS_DEFAULT)
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic [CMD_BITS-1:0]       cmd_data,
   input  wire logic                      cmd_empty,
   output      logic                      cmd_pop,
   blpg_rsp_if.source                     rsp_if,
   output      blpg_pkg::walk_status_type status
);
   import blpg_pkg::*;

   localparam int EB = error_bits(COORD_BITS);

   typedef struct packed {
      logic [COORD_BITS-1:0]  start_major;
      logic [COORD_BITS-1:0]  start_minor;
      logic [COORD_BITS-1:0]  stop_major;
      logic signed [EB-1:0]   error_init;
      logic signed [EB-1:0]   inc_step;
      logic signed [EB-1:0]   inc_hold;
      logic                   step_down;
      logic                   steep;
      logic [COLOUR_BITS-1:0] colour;
   } cmd_type;

   cmd_type cmd;

   logic                   busy_ff;
   logic [COORD_BITS-1:0]  major_ff, minor_ff, stop_ff;
   logic signed [EB-1:0]   err_ff, inc_step_ff, inc_hold_ff;
   logic                   step_down_ff, steep_ff;
   logic [COLOUR_BITS-1:0] colour_ff;

   logic                   out_valid_ff;
   logic [COORD_BITS-1:0]  out_x_ff, out_y_ff;
   logic [COLOUR_BITS-1:0] out_colour_ff;
   logic                   out_last_ff;

   logic emit, fin, err_pos;

   assign cmd     = cmd_type'(cmd_data);
   assign emit    = busy_ff && (!out_valid_ff || rsp_if.ready);
   assign fin     = major_ff == stop_ff;
   assign err_pos = !err_ff[EB-1] && (err_ff != '0);
   assign cmd_pop = !busy_ff && !cmd_empty;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (cmd_pop) begin
            busy_ff <= 1'b1;
         end else if (emit && fin) begin
            busy_ff <= 1'b0;
         end
         if (emit) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_if.ready) begin
            out_valid_ff <= 1'b0;
         end
      end
      if (cmd_pop) begin
         major_ff     <= cmd.start_major;
         minor_ff     <= cmd.start_minor;
         stop_ff      <= cmd.stop_major;
         err_ff       <= cmd.error_init;
         inc_step_ff  <= cmd.inc_step;
         inc_hold_ff  <= cmd.inc_hold;
         step_down_ff <= cmd.step_down;
         steep_ff     <= cmd.steep;
         colour_ff    <= cmd.colour;
      end else if (emit) begin
         major_ff <= major_ff + 1'b1;
         if (err_pos) begin
            minor_ff <= step_down_ff ? minor_ff - 1'b1 : minor_ff + 1'b1;
            err_ff   <= err_ff + inc_step_ff;
         end else begin
            err_ff   <= err_ff + inc_hold_ff;
         end
      end
      if (emit) begin
         out_x_ff      <= steep_ff ? minor_ff : major_ff;
         out_y_ff      <= steep_ff ? major_ff : minor_ff;
         out_colour_ff <= colour_ff;
         out_last_ff   <= fin;
      end
   end

   assign rsp_if.valid        = out_valid_ff;
   assign rsp_if.pixel_x      = out_x_ff;
   assign rsp_if.pixel_y      = out_y_ff;
   assign rsp_if.pixel_colour = out_colour_ff;
   assign rsp_if.last         = out_last_ff;

   assign status.busy      = busy_ff;
   assign status.emit      = emit;
   assign status.emit_last = emit && fin;
   assign status.take      = cmd_pop;

endmodule

`default_nettype wire

// ===== rtl/core/bresenham_line_pixel_generator_top.sv =====
// Top level of the Bresenham line pixel generator: front end, command queue
// and pixel walker. Depends on blpg_pkg, blpg_if, blpg_front, blpg_queue
// and blpg_walker.
//
//   channel | direction | payload
//   req_if  | in        | start_x, start_y, end_x, end_y, colour (one line per item)
//   rsp_if  | out       | pixel_x, pixel_y, pixel_colour, last (one pixel per item)
//
// A line of n pixels (n = major-axis length + 1, up to 2^COORD_BITS) is emitted by the walker
// at one pixel per cycle while rsp_if accepts; the walker takes the next line only after the last pixel.
// An accepted command is registered in the front end, written into the queue and loaded by the idle walker,
// and its first pixel is then offered on rsp_if from the walker's output register.
// The front end and the two-entry queue accept new commands while a line is walked.
// Reset is synchronous and active high; stalls on rsp_if hold the walker in place.
`default_nettype none

module bresenham_line_pixel_generator_top #(
   parameter int COORD_BITS = blpg_pkg::COORD_BITS_DEFAULT
) (
   input wire logic    clock,
   input wire logic    reset,
   blpg_req_if.sink    req_if,
   blpg_rsp_if.source  rsp_if
);
   import blpg_pkg::*;

   localparam int CMD_BITS = cmd_bits(COORD_BITS);

   logic                push, full, pop, empty;
   logic [CMD_BITS-1:0] push_data, pop_data;
   walk_status_type     status;

   blpg_front #(
      .COORD_BITS (COORD_BITS),
      .CMD_BITS   (CMD_BITS)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .req_if    (req_if),
      .push      (push),
      .push_data (push_data),
      .full      (full)
   );

   blpg_queue #(
      .DATA_BITS (CMD_BITS)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .full      (full),
      .pop       (pop),
      .pop_data  (pop_data),
      .empty     (empty)
   );

   blpg_walker #(
      .COORD_BITS (COORD_BITS),
      .CMD_BITS   (CMD_BITS)
   ) u_walker (
      .clock     (clock),
      .reset     (reset),
      .cmd_data  (pop_data),
      .cmd_empty (empty),
      .cmd_pop   (pop),
      .rsp_if    (rsp_if),
      .status    (status)
   );

   a_push_not_full : assert property (@(posedge clock) disable iff (reset)
      push |-> !full)
      else $error("command pushed into a full queue");

   a_take_when_idle : assert property (@(posedge clock) disable iff (reset)
      status.take |-> !status.busy && !empty)
      else $error("walker took a command while busy or from an empty queue");

   a_last_ends_line : assert property (@(posedge clock) disable iff (reset)
      status.emit_last |=> !status.busy)
      else $error("walker still busy after the last pixel");

   a_last_marked : assert property (@(posedge clock) disable iff (reset)
      status.emit_last |=> rsp_if.valid && rsp_if.last)
      else $error("final pixel not presented with last set");

endmodule

`default_nettype wire

// ===== sim/bresenham_line_pixel_generator_top_test.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for bresenham_line_pixel_generator_top: it traces each accepted
// line in software and compares every emitted pixel with the traced ones, in order.
// Depends on blpg_pkg, blpg_if and the generator RTL.

module bresenham_line_pixel_generator_top_test;
   import blpg_pkg::*;

   localparam int COORD_BITS = COORD_BITS_DEFAULT;
   localparam int COORD_MAX = (1 << COORD_BITS) - 1;
   localparam int RANDOM_LINES = 112;
   localparam int LONG_HOLD = 400;
   localparam int SETTLE_CYCLES = 100;
   localparam longint RUN_LIMIT_NS = 4_000_000;

   typedef logic [COORD_BITS-1:0] coord_type;

   typedef struct packed {
      coord_type               start_x;
      coord_type               start_y;
      coord_type               end_x;
      coord_type               end_y;
      logic [COLOUR_BITS-1:0]  colour;
   } line_cmd_type;

   typedef struct packed {
      coord_type               x;
      coord_type               y;
      logic [COLOUR_BITS-1:0]  colour;
      logic                    last;
   } pixel_type;

   class pixel_ledger;
      pixel_type expected_pixels[$];
      int unsigned failures;

      function void note_line(line_cmd_type cmd);
         int x0, y0, x1, y1, dx, dy;
         int a0, b0, a1, b1, d_major, d_minor, decision, major, minor;
         bit steep, step_down, fin;
         pixel_type pix;
         x0 = int'(cmd.start_x);
         y0 = int'(cmd.start_y);
         x1 = int'(cmd.end_x);
         y1 = int'(cmd.end_y);
         dx = (x1 > x0) ? x1 - x0 : x0 - x1;
         dy = (y1 > y0) ? y1 - y0 : y0 - y1;
         steep = !(dy < dx);
         if (!steep) begin
            if (x0 > x1) begin
               a0 = x1; b0 = y1; a1 = x0; b1 = y0;
            end else begin
               a0 = x0; b0 = y0; a1 = x1; b1 = y1;
            end
         end else begin
            if (y0 > y1) begin
               a0 = y1; b0 = x1; a1 = y0; b1 = x0;
            end else begin
               a0 = y0; b0 = x0; a1 = y1; b1 = x1;
            end
         end
         d_major = a1 - a0;
         d_minor = b1 - b0;
         step_down = (d_minor < 0);
         if (step_down) begin
            d_minor = -d_minor;
         end
         decision = 2 * d_minor - d_major;
         major = a0;
         minor = b0;
         do begin
            fin = (major == a1);
            pix.x = coord_type'(steep ? minor : major);
            pix.y = coord_type'(steep ? major : minor);
            pix.colour = cmd.colour;
            pix.last = fin;
            expected_pixels.push_back(pix);
            if (decision > 0) begin
               minor = step_down ? minor - 1 : minor + 1;
               decision += 2 * (d_minor - d_major);
            end else begin
               decision += 2 * d_minor;
            end
            major++;
         end while (!fin);
      endfunction

      function void check_field(string name, longint unsigned want, longint unsigned got);
         if (want != got) begin
            $error("%s: expected %0h, got %0h", name, want, got);
            failures++;
         end
      endfunction

      function void check_pixel(pixel_type got);
         pixel_type want;
         if (expected_pixels.size() == 0) begin
            $error("pixel (%0d, %0d) arrived with none expected", got.x, got.y);
            failures++;
            return;
         end
         want = expected_pixels.pop_front();
         check_field("pixel_x", 64'(want.x), 64'(got.x));
         check_field("pixel_y", 64'(want.y), 64'(got.y));
         check_field("pixel_colour", 64'(want.colour), 64'(got.colour));
         check_field("last", 64'(want.last), 64'(got.last));
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;
   bit long_hold_pending = 1'b0;
   pixel_ledger ledger = new;

   blpg_req_if #(.COORD_BITS(COORD_BITS)) req_if ();
   blpg_rsp_if #(.COORD_BITS(COORD_BITS)) rsp_if ();

   bresenham_line_pixel_generator_top #(.COORD_BITS(COORD_BITS)) DUT (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_if),
      .rsp_if (rsp_if)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic int clamp_coord(int v);
      return (v < 0) ? 0 : ((v > COORD_MAX) ? COORD_MAX : v);
   endfunction

   function automatic line_cmd_type make_line(int sx, int sy, int ex, int ey,
                                              logic [COLOUR_BITS-1:0] colour);
      line_cmd_type cmd;
      cmd.start_x = coord_type'(sx);
      cmd.start_y = coord_type'(sy);
      cmd.end_x = coord_type'(ex);
      cmd.end_y = coord_type'(ey);
      cmd.colour = colour;
      return cmd;
   endfunction

   function automatic line_cmd_type random_line();
      int sx, sy, ex, ey, len;
      sx = $urandom_range(0, COORD_MAX);
      sy = $urandom_range(0, COORD_MAX);
      ex = $urandom_range(0, COORD_MAX);
      ey = $urandom_range(0, COORD_MAX);
      case ($urandom_range(0, 9))
         6, 7: begin
            ex = clamp_coord(sx + int'($urandom_range(0, 8)) - 4);
            ey = clamp_coord(sy + int'($urandom_range(0, 8)) - 4);
         end
         8: begin
            case ($urandom_range(0, 2))
               0: ey = sy;
               1: ex = sx;
               default: begin
                  len = $urandom_range(0, COORD_MAX - sx);
                  ex = sx + len;
                  if ($urandom_range(0, 1)) begin
                     sy = 0;
                     ey = len;
                  end else begin
                     sy = COORD_MAX;
                     ey = COORD_MAX - len;
                  end
               end
            endcase
         end
         9: begin
            sx = $urandom_range(0, 1) * COORD_MAX;
            sy = $urandom_range(0, 1) * COORD_MAX;
            ex = $urandom_range(0, 1) * COORD_MAX;
            ey = $urandom_range(0, 1) * COORD_MAX;
         end
         default: ;
      endcase
      if ($urandom_range(0, 1)) begin
         return make_line(ex, ey, sx, sy, $urandom());
      end
      return make_line(sx, sy, ex, ey, $urandom());
   endfunction

   task automatic send_line(input line_cmd_type cmd);
      @(negedge clock);
      req_if.valid = 1'b1;
      req_if.start_x = cmd.start_x;
      req_if.start_y = cmd.start_y;
      req_if.end_x = cmd.end_x;
      req_if.end_y = cmd.end_y;
      req_if.colour = cmd.colour;
      do @(posedge clock); while (!req_if.ready);
      ledger.note_line(cmd);
   endtask

   task automatic pause(input int cycles);
      repeat (cycles) begin
         @(negedge clock);
         req_if.valid = 1'b0;
      end
   endtask

   task automatic wait_for_all_pixels();
      @(negedge clock);
      req_if.valid = 1'b0;
      while (ledger.expected_pixels.size() != 0) @(posedge clock);
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         ledger.check_pixel(pixel_type'{rsp_if.pixel_x, rsp_if.pixel_y,
                                        rsp_if.pixel_colour, rsp_if.last});
      end
   end

   initial begin : receiver
      int hold_left, phase_left, style;
      hold_left = 0;
      phase_left = 0;
      style = 0;
      rsp_if.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (long_hold_pending) begin
            long_hold_pending = 1'b0;
            hold_left = LONG_HOLD;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_if.ready = 1'b0;
         end else begin
            if (phase_left == 0) begin
               style = $urandom_range(0, 3);
               phase_left = $urandom_range(16, 96);
            end
            phase_left--;
            case (style)
               0: rsp_if.ready = 1'b1;
               1: rsp_if.ready = 1'($urandom_range(0, 1));
               2: rsp_if.ready = ($urandom_range(0, 3) == 0);
               default: rsp_if.ready = (phase_left % 6 < 4);
            endcase
         end
      end
   end

   initial begin : stimulus
      line_cmd_type directed_lines[$];
      int burst_left;
      bit gaps_on;
      req_if.valid = 1'b0;
      req_if.start_x = '0;
      req_if.start_y = '0;
      req_if.end_x = '0;
      req_if.end_y = '0;
      req_if.colour = '0;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Single points, full-length axis lines, both diagonals, and shallow and steep
      // lines in both directions and both endpoint orders.
      directed_lines.push_back(make_line(0, 0, 0, 0, 32'h0000_0000));
      directed_lines.push_back(make_line(COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX,
                                         32'hFFFF_FFFF));
      directed_lines.push_back(make_line(0, 0, COORD_MAX, 0, 32'hAAAA_AAAA));
      directed_lines.push_back(make_line(COORD_MAX, COORD_MAX, 0, COORD_MAX, 32'h5555_5555));
      directed_lines.push_back(make_line(0, 0, 0, COORD_MAX, 32'hFFFF_FFFF));
      directed_lines.push_back(make_line(5, COORD_MAX, 5, 0, 32'h0000_0000));
      directed_lines.push_back(make_line(0, 0, COORD_MAX, COORD_MAX, 32'h1234_5678));
      directed_lines.push_back(make_line(COORD_MAX, 0, 0, COORD_MAX, 32'h8765_4321));
      directed_lines.push_back(make_line(0, 40, COORD_MAX, 10, 32'hDEAD_BEEF));
      directed_lines.push_back(make_line(COORD_MAX, 10, 0, 40, 32'h0F0F_0F0F));
      directed_lines.push_back(make_line(10, 0, 20, COORD_MAX, 32'hF0F0_F0F0));
      directed_lines.push_back(make_line(20, COORD_MAX, 10, 0, 32'h0000_0001));
      directed_lines.push_back(make_line(50, 0, 10, COORD_MAX, 32'h8000_0000));
      directed_lines.push_back(make_line(3, 3, 4, 3, 32'hCAFE_F00D));
      directed_lines.push_back(make_line(3, 3, 3, 4, 32'h0BAD_CAFE));
      directed_lines.push_back(make_line(20, 20, 25, 24, 32'h1357_9BDF));
      directed_lines.push_back(make_line(20, 20, 24, 25, 32'h2468_ACE0));
      directed_lines.push_back(make_line(0, COORD_MAX, COORD_MAX, COORD_MAX - 1,
                                         32'h7FFF_FFFF));
      foreach (directed_lines[i]) begin
         pause($urandom_range(0, 2));
         send_line(directed_lines[i]);
      end
      wait_for_all_pixels();

      burst_left = 0;
      gaps_on = 1'b1;
      for (int n = 0; n < RANDOM_LINES; n++) begin
         if (n % 32 == 0) begin
            gaps_on = ($urandom_range(0, 2) != 0);
         end
         // The output is held off for a long stretch while lines keep coming, so
         // the input side has to back up.
         if (n == 50) begin
            long_hold_pending = 1'b1;
            gaps_on = 1'b0;
         end
         if (n == 100) begin
            wait_for_all_pixels();
         end
         if (burst_left == 0) begin
            burst_left = $urandom_range(1, 10);
            if (gaps_on) begin
               pause($urandom_range(1, 6));
            end
         end
         burst_left--;
         send_line(random_line());
      end

      wait_for_all_pixels();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (ledger.failures == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

   initial begin : watchdog
      #(RUN_LIMIT_NS);
      $display("CHECKS FAILED");
      $finish;
   end

endmodule
